// ===== hw/rtl/sms_pkg.sv =====
// shared types and constants for the smallest-m sorted selector
`default_nettype none

package sms_pkg;

    localparam int VALUE_W = 32;
    localparam int KEEP_W  = 5;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [KEEP_W-1:0] keep_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sms_cell.sv =====
// one cell of the sorted insertion chain
`default_nettype none

module sms_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  sms_pkg::cell_ctrl_t ctrl,
    input  sms_pkg::value_t     in_value,
    input  wire                 left_valid,
    input  wire                 left_disp,
    input  sms_pkg::value_t     left_value,
    input  wire                 right_valid,
    input  sms_pkg::value_t     right_value,
    output sms_pkg::value_t     value_out,
    output logic                valid_out,
    output logic                disp_out
);
    import sms_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;
    logic   disp;
    logic   take;

    // displaced when the new word sorts strictly before the held one
    assign disp = valid_reg && (in_value < value_reg);
    assign take = disp || (!valid_reg && left_valid);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (take)
            begin
                value_next = left_disp ? left_value : in_value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_out = value_reg;
    assign valid_out = valid_reg;
    assign disp_out  = disp;

endmodule

`default_nettype wire

// ===== hw/rtl/smallest_m_sorted_selector.sv =====
// top level of the smallest-m sorted selector
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------
//  input    | in_valid / in_stall | value, batch_end
//  output   | out_valid/out_stall | sorted_value, final_of_run
//  config   | cfg_valid/cfg_ready | keep_count
//
//  one input word per cycle while the batch fills the chain
//  after the batch-end word, n = min(held, keep_count) words drain,
//  one output word per cycle, set by the chain shifting toward cell zero
//  input is stalled during drain; output stall pauses the drain
//  reset empties the chain and sets keep_count to 16
`default_nettype none

module smallest_m_sorted_selector #(
    parameter int MAX_KEEP = 16
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_stall,
    input  sms_pkg::value_t value,
    input  wire             batch_end,
    output logic            out_valid,
    input  wire             out_stall,
    output sms_pkg::value_t sorted_value,
    output logic            final_of_run,
    input  wire             cfg_valid,
    output logic            cfg_ready,
    input  sms_pkg::keep_t  keep_count
);
    import sms_pkg::*;

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int KW = (CW > KEEP_W) ? CW : KEEP_W;

    state_t         state_reg;
    state_t         state_next;
    keep_t          keep_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  remain_reg;
    logic [CW-1:0]  remain_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    value_t         out_value_reg;
    logic           out_final_reg;

    cell_ctrl_t     ctrl;
    value_t         cell_value [MAX_KEEP];
    logic [MAX_KEEP-1:0] cell_valid;
    logic [MAX_KEEP-1:0] cell_disp;

    logic           in_accept;
    logic           out_load;
    logic [CW-1:0]  count_ins;
    logic [KW-1:0]  keep_ext;
    logic [CW-1:0]  keep_eff;
    logic [CW-1:0]  emit_n;

    assign in_stall  = (state_reg != ST_FILL);
    assign cfg_ready = (state_reg == ST_FILL);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_DRAIN) && (remain_reg != '0)
                       && (!out_valid_reg || !out_stall);

    assign count_ins = (count_reg == CW'(MAX_KEEP)) ? count_reg : count_reg + 1'b1;
    assign keep_ext  = KW'(keep_reg);
    assign keep_eff  = (keep_ext > KW'(MAX_KEEP)) ? CW'(MAX_KEEP) : CW'(keep_ext);
    assign emit_n    = (count_ins < keep_eff) ? count_ins : keep_eff;

    // chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++)
        begin : g_cell
            logic   lv;
            logic   ld;
            value_t lval;
            logic   rv;
            value_t rval;
            if (gi == 0)
            begin : g_first
                assign lv   = 1'b1;
                assign ld   = 1'b0;
                assign lval = value;
            end
            else
            begin : g_mid
                assign lv   = cell_valid[gi-1];
                assign ld   = cell_disp[gi-1];
                assign lval = cell_value[gi-1];
            end
            if (gi == MAX_KEEP - 1)
            begin : g_last
                assign rv   = 1'b0;
                assign rval = cell_value[gi];
            end
            else
            begin : g_inner
                assign rv   = cell_valid[gi+1];
                assign rval = cell_value[gi+1];
            end
            sms_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .in_value    (value),
                .left_valid  (lv),
                .left_disp   (ld),
                .left_value  (lval),
                .right_valid (rv),
                .right_value (rval),
                .value_out   (cell_value[gi]),
                .valid_out   (cell_valid[gi]),
                .disp_out    (cell_disp[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctrl           = '0;
        case (state_reg)
            ST_FILL:
            begin
                if (in_accept)
                begin
                    if (batch_end && (emit_n == '0))
                    begin
                        ctrl.clear = 1'b1;
                        count_next = '0;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_ins;
                        if (batch_end)
                        begin
                            remain_next = emit_n;
                            state_next  = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == CW'(1))
                    begin
                        ctrl.clear = 1'b1;
                        count_next = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        ctrl.shift = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            keep_reg      <= KEEP_W'(16);
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                keep_reg <= keep_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= cell_value[0];
            out_final_reg <= (remain_reg == CW'(1));
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign final_of_run = out_final_reg;

`ifndef SYNTHESIS
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + 1'b1)) == '0)
        else $error("chain valid bits not contiguous from cell zero");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (32'(count_reg) == 32'($countones(cell_valid))))
        else $error("fill count disagrees with chain occupancy");

    a_drain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (remain_reg != '0) && cell_valid[0])
        else $error("drain with nothing left to emit");

    a_final_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (remain_reg == CW'(1))) |=> (state_reg == ST_FILL) && (cell_valid == '0))
        else $error("chain not cleared after final word");
`endif

endmodule

`default_nettype wire

// ===== test/sms_selector_board_pkg.sv =====
// scoreboard class that tracks the kept smallest values and checks each sorted word
`timescale 1ns / 100ps

package sms_selector_board_pkg;

    import sms_pkg::*;

    localparam int unsigned CHAIN_DEPTH = 16;

    typedef struct {
        value_t value;
        logic   final_mark;
    } sorted_word_t;

    class smallest_values_board;

        value_t        chain[CHAIN_DEPTH];
        int unsigned   held;
        int unsigned   keep_limit;
        int unsigned   failures;
        sorted_word_t  due_words[$];

        function new();
            held       = 0;
            keep_limit = 16;
            failures   = 0;
        endfunction

        function void set_keep(keep_t k);
            keep_limit = k;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void note_value(value_t v, logic ends_batch);
            int unsigned  pos;
            int unsigned  lim;
            int unsigned  n;
            sorted_word_t w;
            pos = 0;
            while (pos < held && !(v < chain[pos]))
                pos++;
            if (pos < CHAIN_DEPTH)
            begin
                if (held < CHAIN_DEPTH)
                    held++;
                for (int unsigned i = held - 1; i > pos; i--)
                    chain[i] = chain[i - 1];
                chain[pos] = v;
            end
            if (ends_batch)
            begin
                lim = (keep_limit > CHAIN_DEPTH) ? CHAIN_DEPTH : keep_limit;
                n   = (held < lim) ? held : lim;
                for (int unsigned i = 0; i < n; i++)
                begin
                    w.value      = chain[i];
                    w.final_mark = (i + 1 == n);
                    due_words.insert(due_words.size(), w);
                end
                held = 0;
            end
        endfunction

        function void check_word(value_t got, logic got_final);
            sorted_word_t want;
            if (due_words.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected word: got %0d final %0b", got, got_final);
                return;
            end
            want = due_words.pop_front();
            if (got !== want.value || got_final !== want.final_mark)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected %0d final %0b, got %0d final %0b",
                             want.value, want.final_mark, got, got_final);
            end
        endfunction

    endclass

endpackage

// ===== test/smallest_m_sorted_selector_tb.sv =====
// testbench for the smallest-m sorted selector: directed and random batches, scoreboard check
`timescale 1ns / 100ps

module smallest_m_sorted_selector_tb;

    import sms_pkg::*;
    import sms_selector_board_pkg::*;

    localparam int unsigned RANDOM_WORDS  = 410;
    localparam int unsigned DRAIN_SETTLE  = 40;
    localparam int unsigned LIMIT_CYCLES  = 200000;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    value_t value;
    logic   batch_end;
    logic   out_valid;
    logic   out_stall;
    value_t sorted_value;
    logic   final_of_run;
    logic   cfg_valid;
    logic   cfg_ready;
    keep_t  keep_count;

    logic        calm;
    int unsigned cycles;
    int unsigned random_sent;

    smallest_values_board board;

    smallest_m_sorted_selector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .batch_end    (batch_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .final_of_run (final_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .keep_count   (keep_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL smallest_m_sorted_selector");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 15);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_word(sorted_value, final_of_run);

    task automatic push_word(input value_t v, input logic ends_batch);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        value     <= v;
        batch_end <= ends_batch;
        do
            @(posedge clk);
        while (in_stall);
        board.note_value(v, ends_batch);
        if (random_sent < RANDOM_WORDS && board.held == 0 && !ends_batch)
            random_sent = random_sent;
    endtask

    // sender stops until every expected word is out and the chain has settled
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    task automatic write_keep(input keep_t k);
        quiesce();
        @(negedge clk);
        cfg_valid  <= 1'b1;
        keep_count <= k;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_keep(k);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic value_t pick_value();
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3, 4: return value_t'(int'($urandom_range(16)) - 8);
            default: return value_t'($urandom);
        endcase
    endfunction

    initial
    begin
        int unsigned batch_len;
        int unsigned batch_no;
        board       = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        value       = '0;
        batch_end   = 1'b0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        keep_count  = keep_t'(16);
        calm        = 1'b0;
        cycles      = 0;
        random_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // extremes and equal values, fewer values than the default keep count
        push_word(32'sh7fffffff, 1'b0);
        push_word(32'sh80000000, 1'b0);
        push_word(32'sh00000000, 1'b0);
        push_word(-32'sd1, 1'b0);
        push_word(32'sd1, 1'b0);
        push_word(32'sd5, 1'b0);
        push_word(32'sd5, 1'b1);

        // zero keep count emits nothing
        write_keep(keep_t'(0));
        push_word(32'sd3, 1'b0);
        push_word(-32'sd3, 1'b1);

        // keep count above chain depth, single-word batch
        write_keep(keep_t'(31));
        push_word(32'sd42, 1'b1);

        write_keep(keep_t'(2));
        push_word(32'sd9, 1'b0);
        push_word(32'sd9, 1'b0);
        push_word(32'sd9, 1'b0);
        push_word(32'sd12, 1'b1);

        // keep count changed mid-batch
        push_word(32'sd7, 1'b0);
        push_word(-32'sd7, 1'b0);
        push_word(32'sd100, 1'b0);
        write_keep(keep_t'(3));
        push_word(32'sd50, 1'b0);
        push_word(-32'sd50, 1'b1);

        write_keep(keep_t'(16));

        batch_no = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            calm = (batch_no >= 10 && batch_no < 16);
            if (batch_no == 5)
                quiesce();
            else if (batch_no > 0 && $urandom_range(2) == 0)
            begin
                if ($urandom_range(3) == 0)
                    write_keep(keep_t'($urandom_range(31)));
                else
                    write_keep(keep_t'($urandom_range(16, 1)));
            end
            if ($urandom_range(3) == 0)
                batch_len = $urandom_range(40, 17);
            else
                batch_len = $urandom_range(20, 1);
            for (int unsigned i = 0; i < batch_len; i++)
            begin
                push_word(pick_value(), i + 1 == batch_len);
                random_sent++;
            end
            batch_no++;
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
        if (board.failures == 0)
            $display("PASS smallest_m_sorted_selector");
        else
            $display("FAIL smallest_m_sorted_selector");
        $finish;
    end

endmodule
